// ----- rtl/plist_pkg.sv -----
`default_nettype none
package plist_pkg;

  // Request kinds; the unused code behaves as a read
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_SMALL = 3'd2,
    ST_LARGE = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_TAKE  = 8'b0000_1000,
    S_SHRD  = 8'b0001_0000,
    S_SHWR  = 8'b0010_0000,
    S_PUT   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/plist_ram.sv -----
`default_nettype none
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
`default_nettype none
// Channel   Dir  tdata (low bit up)                 tuser
// s_        in   position[5:0], value[WORD_WIDTH]    kind[1:0]
// m_        out  word_out[WORD_WIDTH], length        status[2:0]
//
// One request at a time: accept, evaluate, result (held in S_FIN while m_ stalls).
// Insert shifts the tail up, then puts; read fetches, takes; remove also shifts down.
// Each moved word costs a read and a write on the list RAM.
// Errors skip to the result. rst clears state, count and m_tvalid; RAM needs no clear.
// A finished result waits in the output register while the next request is accepted.
module positional_list_engine
  import plist_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // position[5:0], value, zero pad
  input  wire logic [((6+WORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0] s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // word_out, length, zero pad
  output logic [((WORD_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata,
  // status[2:0]
  output logic [2:0] m_tuser
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int LW  = $clog2(CAPACITY + 1);
  localparam int AW  = (LW + 2 > 7) ? LW + 2 : 7;
  localparam int ODW = ((WORD_WIDTH + LW + 7) / 8) * 8;

  state_t state, state_next;

  logic [1:0]            kind;
  logic signed [5:0]     pos;
  logic [WORD_WIDTH-1:0] value;
  logic [LW-1:0]         count;
  logic [IW-1:0]         ptr;
  logic [IW-1:0]         idx;
  status_t               status;
  logic [WORD_WIDTH-1:0] word;

  logic [WORD_WIDTH-1:0] out_word;
  logic [LW-1:0]         out_len;
  status_t               out_status;

  logic                  is_ins;
  logic                  is_rem;
  logic signed [AW-1:0]  pos_s;
  logic signed [AW-1:0]  cnt_s;
  logic signed [AW-1:0]  adj;
  logic                  too_small;
  logic                  too_large;
  logic [IW-1:0]         idx_dn;
  logic [IW-1:0]         idx_up;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [IW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;
  logic                  out_free;

  assign is_ins = (kind == KIND_INSERT);
  assign is_rem = (kind == KIND_REMOVE);

  // Fold a negative position onto the list and range check it
  assign pos_s = {{(AW-6){pos[5]}}, pos};
  assign cnt_s = AW'(count);
  assign adj   = pos[5] ? (pos_s + cnt_s + (is_ins ? AW'(1) : AW'(0))) : pos_s;
  assign too_small = adj[AW-1];
  assign too_large = is_ins ? (adj > cnt_s) : (adj >= cnt_s);

  assign idx_dn = idx - IW'(1);
  assign idx_up = idx + IW'(1);

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // RAM ports: shift moves one word per read/write pair
  assign rd_addr = (state == S_FETCH) ? ptr : (is_ins ? idx_dn : idx_up);
  assign wr_en   = (state == S_SHWR) || (state == S_PUT);
  assign wr_addr = (state == S_PUT) ? ptr : idx;
  assign wr_data = (state == S_PUT) ? value : rd_data;

  plist_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (is_ins) begin
          if (count == LW'(CAPACITY) || too_small || too_large) begin
            state_next = S_FIN;
          end else if (adj < cnt_s) begin
            state_next = S_SHRD;
          end else begin
            state_next = S_PUT;
          end
        end else if (count == '0 || too_small || too_large) begin
          state_next = S_FIN;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_TAKE;
      S_TAKE: begin
        if (is_rem && (LW'(ptr) + LW'(1) < count)) state_next = S_SHRD;
        else state_next = S_FIN;
      end
      S_SHRD: state_next = S_SHWR;
      S_SHWR: begin
        if (is_ins) begin
          state_next = (idx_dn > ptr) ? S_SHRD : S_PUT;
        end else begin
          state_next = (LW'(idx) + LW'(1) < count) ? S_SHRD : S_FIN;
        end
      end
      S_PUT: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // grow on insert, shrink once the removed word is taken
      if (state == S_PUT) count <= count + LW'(1);
      if (state == S_TAKE && is_rem) count <= count - LW'(1);
      if (state == S_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Request, pointer and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      kind  <= s_tuser;
      pos   <= s_tdata[5:0];
      value <= s_tdata[6 +: WORD_WIDTH];
    end
    if (state == S_EVAL) begin
      word <= '0;
      ptr  <= adj[IW-1:0];
      idx  <= count[IW-1:0];
      if (is_ins && count == LW'(CAPACITY)) status <= ST_FULL;
      else if (!is_ins && count == '0)      status <= ST_EMPTY;
      else if (too_small)                   status <= ST_SMALL;
      else if (too_large)                   status <= ST_LARGE;
      else                                  status <= ST_OK;
    end
    if (state == S_TAKE) begin
      word <= rd_data;
      idx  <= ptr;
    end
    if (state == S_SHWR) begin
      idx <= is_ins ? idx_dn : idx_up;
    end
    if (state == S_FIN && out_free) begin
      out_word   <= word;
      out_len    <= count;
      out_status <= status;
    end
  end

  assign m_tdata = ODW'({out_len, out_word});
  assign m_tuser = out_status;

endmodule
`default_nettype wire
